// File: design/wto_pkg.sv
package wto_pkg;

	// Item kinds on the input channel.
	localparam logic [1:0] KIND_GEN   = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_LOAD  = 2'd2;

	typedef logic [31:0]        phase_t;
	typedef logic signed [15:0] sample_t;
	typedef logic [15:0]        frac_t;

	// Side information that travels with a generate item next to its table reads.
	typedef struct packed {
		phase_t phase;
		frac_t  frac;
	} gen_tag_t;

endpackage

// File: design/wto_ram.sv
module wto_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; read data holds when idle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/wto_interp.sv
module wto_interp
	import wto_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s1_valid,
	input  sample_t  s1_v1,
	input  sample_t  s1_v2,
	input  gen_tag_t s1_tag,
	output logic     s1_free,
	output logic     out_valid,
	input  logic     out_ready,
	output sample_t  sample,
	output phase_t   phase_out
);

	logic               v_s2, v_s3, out_valid_q;
	logic signed [16:0] diff_s2;
	sample_t            v1_s2, v1_s3;
	gen_tag_t           tag_s2;
	phase_t             phase_s3;
	logic signed [33:0] prod_s3;
	sample_t            sample_q;
	phase_t             phase_q;

	logic               out_load, free3, free2;
	logic signed [16:0] diff_d;
	logic signed [33:0] prod_d;
	logic signed [33:0] rnd;
	logic [15:0]        sample_d;

	// Elastic stage control: a stage takes new data when it is empty or drains.
	assign out_load = v_s3 && (!out_valid_q || out_ready);
	assign free3    = !v_s3 || out_load;
	assign free2    = !v_s2 || free3;
	assign s1_free  = free2;

	// Difference of the two neighbors, product with the fraction, rounded sum.
	assign diff_d   = $signed({s1_v2[15], s1_v2}) - $signed({s1_v1[15], s1_v1});
	assign prod_d   = $signed({1'b0, tag_s2.frac}) * diff_s2;
	assign rnd      = prod_s3 + 34'sd32768;
	assign sample_d = 16'(v1_s3) + rnd[31:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free2) begin
				v_s2 <= s1_valid;
			end
			if (free3) begin
				v_s3 <= v_s2;
			end
			out_valid_q <= out_load || (out_valid_q && !out_ready);
		end
	end

	// Payload registers follow the same enables without reset.
	always_ff @(posedge clk) begin
		if (free2) begin
			diff_s2 <= diff_d;
			v1_s2   <= s1_v1;
			tag_s2  <= s1_tag;
		end
		if (free3) begin
			prod_s3  <= prod_d;
			v1_s3    <= v1_s2;
			phase_s3 <= tag_s2.phase;
		end
		if (out_load) begin
			sample_q <= sample_t'(sample_d);
			phase_q  <= phase_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign phase_out = phase_q;

endmodule

// File: design/wavetable_oscillator_top.sv
// Generate results pass the read stage, s2, s3 and the output register.
// Throughput: one item per cycle unless the output stalls; each generate reads
// both neighbors at once from two copies of the sample store, each with its own
// read port. Write and load items finish at their transfer and give no result.
// Reset clears the phase accumulator and all pipeline valid flags; the sample
// store is not cleared and must be written before it is read.
module wavetable_oscillator_top
	import wto_pkg::*;
#(
	parameter int TABLE_SIZE = 2048,
	parameter int NUM_TABLES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   kind,
	input  logic [31:0]  phase_incr,
	input  logic [2:0]   table_select,
	input  logic [10:0]  write_addr,
	input  logic [15:0]  write_data,
	input  logic [31:0]  new_phase,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [15:0]  sample,
	output logic [31:0]  phase_out
);

	// Index bits: the largest power of two not above the table size.
	localparam int IDX_W = $clog2(TABLE_SIZE + 1) - 1;
	localparam int TSZ   = 1 << IDX_W;
	localparam int DEPTH = NUM_TABLES * TSZ;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic            in_xfer, gen_xfer, wr_xfer, load_xfer;
	logic            wr_ok, s1_free;
	logic [31:0]     tsel_gen, rd_base, rd_sum_a, rd_sum_b, wr_sum;
	logic [IDX_W-1:0] idx_a, idx_b;
	logic [AW-1:0]   rd_addr_a, rd_addr_b, wr_addr;
	sample_t         v1_rd, v2_rd;
	phase_t          phase_acc_q;
	logic            v_s1;
	gen_tag_t        tag_s1;

	assign in_ready  = !v_s1 || s1_free;
	assign in_xfer   = in_valid && in_ready;
	assign gen_xfer  = in_xfer && (kind == KIND_GEN);
	assign wr_xfer   = in_xfer && (kind == KIND_WRITE) && wr_ok;
	assign load_xfer = in_xfer && (kind == KIND_LOAD);

	// Writes outside the table set or beyond the indexed part are dropped.
	assign wr_ok   = (32'(table_select) < 32'(NUM_TABLES)) && (32'(write_addr) < 32'(TSZ));
	assign wr_sum  = (32'(table_select) << IDX_W) + 32'(write_addr);
	assign wr_addr = wr_sum[AW-1:0];

	// Read addresses of the two neighbors; the second wraps within its table.
	assign tsel_gen  = (32'(table_select) < 32'(NUM_TABLES)) ?
		32'(table_select) : 32'(NUM_TABLES - 1);
	assign idx_a     = phase_acc_q[31 -: IDX_W];
	assign idx_b     = idx_a + IDX_W'(1);
	assign rd_base   = tsel_gen << IDX_W;
	assign rd_sum_a  = rd_base + 32'(idx_a);
	assign rd_sum_b  = rd_base + 32'(idx_b);
	assign rd_addr_a = rd_sum_a[AW-1:0];
	assign rd_addr_b = rd_sum_b[AW-1:0];

	// Both store copies take every write, so each read port sees all samples.
	// Items touch the store only at their own transfer, so no forwarding is needed.
	wto_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_store_a (
		.clk  (clk),
		.we   (wr_xfer),
		.waddr(wr_addr),
		.wdata(write_data),
		.re   (gen_xfer),
		.raddr(rd_addr_a),
		.rdata(v1_rd)
	);

	wto_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_store_b (
		.clk  (clk),
		.we   (wr_xfer),
		.waddr(wr_addr),
		.wdata(write_data),
		.re   (gen_xfer),
		.raddr(rd_addr_b),
		.rdata(v2_rd)
	);

	// Phase accumulator and the read-stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			v_s1        <= 1'b0;
		end else begin
			if (gen_xfer) begin
				phase_acc_q <= phase_acc_q + phase_incr;
			end else if (load_xfer) begin
				phase_acc_q <= new_phase;
			end
			if (gen_xfer) begin
				v_s1 <= 1'b1;
			end else if (s1_free) begin
				v_s1 <= 1'b0;
			end
		end
	end

	// The tag holds the advanced phase and the fraction below the index.
	always_ff @(posedge clk) begin
		if (gen_xfer) begin
			tag_s1.phase <= phase_acc_q + phase_incr;
			tag_s1.frac  <= phase_acc_q[31-IDX_W -: 16];
		end
	end

	wto_interp u_interp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (v_s1),
		.s1_v1    (v1_rd),
		.s1_v2    (v2_rd),
		.s1_tag   (tag_s1),
		.s1_free  (s1_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample   (sample),
		.phase_out(phase_out)
	);

`ifndef SYNTH
	// A generate transfer always fills the read stage.
	a_gen_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		gen_xfer |=> v_s1)
		else $error("read stage empty after generate transfer");

	// A generate advances the accumulator by the increment and tags that phase.
	a_gen_phase: assert property (@(posedge clk) disable iff (!arst_n)
		gen_xfer |=> (phase_acc_q == $past(phase_acc_q + phase_incr)) &&
			(tag_s1.phase == phase_acc_q))
		else $error("phase accumulator not advanced by the increment");

	// A load sets the accumulator to the given phase.
	a_load_phase: assert property (@(posedge clk) disable iff (!arst_n)
		load_xfer |=> phase_acc_q == $past(new_phase))
		else $error("phase load not taken");

	// The read stage is never overwritten while its data is still held.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !s1_free) |-> !in_ready)
		else $error("input accepted while read stage is stalled");
`endif

endmodule
